@@ rtl/core/bba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Types, codes and constants shared by the bitmap block allocator modules.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int NUM_BLOCKS_DEF = 4096;
    localparam int MAX_RUN_DEF    = 64;

    localparam int WORD_W   = 8;
    localparam int WBIT_W   = $clog2(WORD_W);
    localparam int TOTAL_W  = 13;
    localparam int BLOCK_W  = 12;
    localparam int COUNT_W  = 7;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int TOTAL_RESET = 4096;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [KIND_W-1:0] {
        K_ALLOC   = 2'd0,
        K_FREE    = 2'd1,
        K_RESERVE = 2'd2,
        K_QUERY   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        S_OK      = 2'd0,
        S_NOSPACE = 2'd1,
        S_RANGE   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_FAIL,
        ST_LOAD,
        ST_GRANT,
        ST_SOP
    } state_t;

    // free bits of one map word that lie below the configured total
    typedef struct packed {
        word_t             avail;
        logic [WBIT_W:0]   free_cnt;
        logic [WBIT_W-1:0] low_idx;
        logic              any;
    } word_eval_t;

endpackage

@@ rtl/core/bba_word_eval.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_word_eval
// Looks at one occupancy word: free bits below the total, their count and
// the lowest of them.
// ----------------------------------------------------------------------------
module bba_word_eval #(
    parameter int WA_W  = 9,
    parameter int TOT_W = 13
) (
    input  bba_pkg::word_t      word,
    input  logic [WA_W-1:0]     addr,
    input  logic [TOT_W-1:0]    total,
    output bba_pkg::word_eval_t ev
);
    import bba_pkg::*;

    logic [TOT_W-WBIT_W-1:0] word_ext;
    logic [TOT_W-WBIT_W-1:0] total_word;
    logic [WBIT_W-1:0]       total_bits;
    word_t                   vmask;

    assign word_ext   = (TOT_W-WBIT_W)'(addr);
    assign total_word = total[TOT_W-1:WBIT_W];
    assign total_bits = total[WBIT_W-1:0];

    always_comb begin
        priority if (word_ext < total_word) begin
            vmask = '1;
        end else if (word_ext == total_word) begin
            vmask = ~(word_t'('1) << total_bits);
        end else begin
            vmask = '0;
        end
    end

    always_comb begin
        ev.avail    = ~word & vmask;
        ev.free_cnt = '0;
        ev.low_idx  = '0;
        for (int i = 0; i < WORD_W; i++) begin
            ev.free_cnt = ev.free_cnt + (WBIT_W+1)'(ev.avail[i]);
        end
        // scan downwards so the lowest free bit wins
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (ev.avail[i]) begin
                ev.low_idx = WBIT_W'(i);
            end
        end
        ev.any = |ev.avail;
    end

endmodule

@@ rtl/core/bitmap_block_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit block allocator over a one-bit-per-block occupancy map held in a
// word-wide synchronous RAM, with a used-block counter.
// ----------------------------------------------------------------------------
//  channel   direction  beat contents
//  s_        in         request: kind (tuser), block and count (tdata)
//  m_        out        result: status (tuser), grant and counts (tdata), tlast
//  cfg_      in         total_blocks write, no read-back
//
//  free, reserve, query: one RAM read of the word, then free and reserve modify and write it.
//  allocate: words are scanned for enough free bits, then walked again while
//  granting, one result beat per block; one RAM port pair serves both.
//  after reset a clearing pass writes every map word to zero before s_tready.
//  a stalled m_ side holds the block in the step that emits its next beat; one beat is buffered.
module bitmap_block_allocator #(
    parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF,
    parameter int MAX_RUN    = bba_pkg::MAX_RUN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [12:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // block[11:0], count[18:12], zero[23:19]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // granted_block[11:0], granted_valid[12],
                                   // block_is_free[13], free_blocks[26:14],
                                   // used_blocks[39:27]
    output logic [1:0]  m_tuser,   // status[1:0]
    output logic        m_tlast
);
    import bba_pkg::*;

    localparam int WORDS  = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
    localparam int TOT_W  = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;
    localparam int ACC_W  = COUNT_W + 1;

    // state and request
    state_t               state_reg, state_next;
    logic [WA_W-1:0]      clr_addr_reg, clr_addr_next;
    kind_t                kind_reg, kind_next;
    logic [BLOCK_W-1:0]   blk_reg, blk_next;
    logic [COUNT_W-1:0]   cnt_reg, cnt_next;
    logic [WA_W-1:0]      scan_w_reg, scan_w_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [WA_W-1:0]      first_w_reg, first_w_next;
    logic                 first_ok_reg, first_ok_next;
    logic [WA_W-1:0]      gw_reg, gw_next;
    logic [COUNT_W-1:0]   rem_reg, rem_next;
    word_t                work_reg, work_next;
    logic [CNT_W-1:0]     used_reg, used_next;
    logic [TOTAL_W-1:0]   total_reg;

    // occupancy RAM
    word_t                map_mem [WORDS];
    word_t                rd_data_reg;
    logic                 mem_we, mem_re;
    logic [WA_W-1:0]      mem_waddr, mem_raddr;
    word_t                mem_wdata;

    // output stage
    logic                 m_tvalid_reg;
    status_t              o_status_reg, o_status;
    logic [BLOCK_W-1:0]   o_granted_reg, o_granted;
    logic                 o_gvalid_reg, o_gvalid;
    logic                 o_last_reg, o_last;
    logic                 o_isfree_reg, o_isfree;
    logic [TOTAL_W-1:0]   o_free_reg, o_used_reg;
    logic                 emit, out_free;

    // derived
    logic [TOT_W-1:0]     eff_total, total_m1, blk_ext, used_ext, free_cnt;
    logic [WA_W-1:0]      last_word, blk_word, start_w;
    logic [WBIT_W-1:0]    blk_bit;
    logic [ACC_W-1:0]     acc_sum;
    word_t                ev_word, bit_mask, grant_word;
    logic [WA_W-1:0]      ev_addr;
    word_eval_t           ev;

    assign eff_total = (TOT_W'(total_reg) < TOT_W'(NUM_BLOCKS)) ?
                       TOT_W'(total_reg) : TOT_W'(NUM_BLOCKS);
    assign total_m1  = eff_total - TOT_W'(1);
    assign last_word = WA_W'(total_m1 >> WBIT_W);
    assign blk_ext   = TOT_W'(blk_reg);
    assign blk_word  = WA_W'(blk_ext >> WBIT_W);
    assign blk_bit   = blk_reg[WBIT_W-1:0];
    assign used_ext  = TOT_W'(used_next);
    assign free_cnt  = (eff_total > used_ext) ? (eff_total - used_ext) : '0;

    assign ev_word = (state_reg == ST_GRANT) ? work_reg : rd_data_reg;
    assign ev_addr = (state_reg == ST_GRANT) ? gw_reg : scan_w_reg;

    bba_word_eval #(
        .WA_W  (WA_W),
        .TOT_W (TOT_W)
    ) u_eval (
        .word  (ev_word),
        .addr  (ev_addr),
        .total (eff_total),
        .ev    (ev)
    );

    assign acc_sum    = acc_reg + ACC_W'(ev.free_cnt);
    assign start_w    = first_ok_reg ? first_w_reg : scan_w_reg;
    assign grant_word = work_reg | (word_t'(1) << ev.low_idx);
    assign bit_mask   = word_t'(1) << blk_bit;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        kind_next     = kind_reg;
        blk_next      = blk_reg;
        cnt_next      = cnt_reg;
        scan_w_next   = scan_w_reg;
        acc_next      = acc_reg;
        first_w_next  = first_w_reg;
        first_ok_next = first_ok_reg;
        gw_next       = gw_reg;
        rem_next      = rem_reg;
        work_next     = work_reg;
        used_next     = used_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = '0;
        emit          = 1'b0;
        o_status      = S_OK;
        o_granted     = '0;
        o_gvalid      = 1'b0;
        o_last        = 1'b1;
        o_isfree      = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                if (clr_addr_reg == WA_W'(WORDS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + WA_W'(1);
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next  = kind_t'(s_tuser);
                    blk_next   = s_tdata[BLOCK_W-1:0];
                    cnt_next   = s_tdata[BLOCK_W+COUNT_W-1:BLOCK_W];
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (kind_reg == K_ALLOC) begin
                    priority if (cnt_reg == '0) begin
                        if (out_free) begin
                            emit       = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end else if (cnt_reg > COUNT_W'(MAX_RUN) || eff_total == '0) begin
                        state_next = ST_FAIL;
                    end else begin
                        mem_re        = 1'b1;
                        mem_raddr     = '0;
                        scan_w_next   = '0;
                        acc_next      = '0;
                        first_ok_next = 1'b0;
                        state_next    = ST_SCAN;
                    end
                end else if (blk_ext >= eff_total) begin
                    if (out_free) begin
                        emit       = 1'b1;
                        o_status   = S_RANGE;
                        state_next = ST_IDLE;
                    end
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = blk_word;
                    state_next = ST_SOP;
                end
            end
            ST_SCAN: begin
                if (!first_ok_reg && ev.any) begin
                    first_ok_next = 1'b1;
                    first_w_next  = scan_w_reg;
                end
                priority if (acc_sum >= ACC_W'(cnt_reg)) begin
                    // enough room: book the whole run now, every beat carries it
                    used_next  = used_reg + CNT_W'(cnt_reg);
                    rem_next   = cnt_reg;
                    gw_next    = start_w;
                    mem_re     = 1'b1;
                    mem_raddr  = start_w;
                    state_next = ST_LOAD;
                end else if (scan_w_reg == last_word) begin
                    state_next = ST_FAIL;
                end else begin
                    acc_next    = acc_sum;
                    mem_re      = 1'b1;
                    mem_raddr   = scan_w_reg + WA_W'(1);
                    scan_w_next = scan_w_reg + WA_W'(1);
                end
            end
            ST_FAIL: begin
                if (out_free) begin
                    emit       = 1'b1;
                    o_status   = S_NOSPACE;
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD: begin
                work_next  = rd_data_reg;
                state_next = ST_GRANT;
            end
            ST_GRANT: begin
                if (!ev.any) begin
                    // word used up: write it back and fetch the next one
                    mem_we     = 1'b1;
                    mem_waddr  = gw_reg;
                    mem_wdata  = work_reg;
                    mem_re     = 1'b1;
                    mem_raddr  = gw_reg + WA_W'(1);
                    gw_next    = gw_reg + WA_W'(1);
                    state_next = ST_LOAD;
                end else if (out_free) begin
                    emit      = 1'b1;
                    o_gvalid  = 1'b1;
                    o_granted = BLOCK_W'({gw_reg, ev.low_idx});
                    o_last    = (rem_reg == COUNT_W'(1));
                    work_next = grant_word;
                    rem_next  = rem_reg - COUNT_W'(1);
                    if (rem_reg == COUNT_W'(1)) begin
                        mem_we     = 1'b1;
                        mem_waddr  = gw_reg;
                        mem_wdata  = grant_word;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SOP: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    unique case (kind_reg)
                        K_FREE: begin
                            if (rd_data_reg[blk_bit]) begin
                                mem_we    = 1'b1;
                                mem_waddr = blk_word;
                                mem_wdata = rd_data_reg & ~bit_mask;
                                used_next = used_reg - CNT_W'(1);
                            end
                        end
                        K_RESERVE: begin
                            if (!rd_data_reg[blk_bit]) begin
                                mem_we    = 1'b1;
                                mem_waddr = blk_word;
                                mem_wdata = rd_data_reg | bit_mask;
                                used_next = used_reg + CNT_W'(1);
                            end
                        end
                        K_QUERY: begin
                            o_isfree = !rd_data_reg[blk_bit];
                        end
                        K_ALLOC: begin
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            used_reg     <= '0;
            total_reg    <= TOTAL_W'(TOTAL_RESET);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            used_reg     <= used_next;
            if (cfg_wr_en) begin
                total_reg <= cfg_wr_data;
            end
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        blk_reg      <= blk_next;
        cnt_reg      <= cnt_next;
        scan_w_reg   <= scan_w_next;
        acc_reg      <= acc_next;
        first_w_reg  <= first_w_next;
        first_ok_reg <= first_ok_next;
        gw_reg       <= gw_next;
        rem_reg      <= rem_next;
        work_reg     <= work_next;
        if (emit) begin
            o_status_reg  <= o_status;
            o_granted_reg <= o_granted;
            o_gvalid_reg  <= o_gvalid;
            o_last_reg    <= o_last;
            o_isfree_reg  <= o_isfree;
            o_free_reg    <= TOTAL_W'(free_cnt);
            o_used_reg    <= TOTAL_W'(used_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= map_mem[mem_raddr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = o_status_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {o_used_reg, o_free_reg, o_isfree_reg, o_gvalid_reg, o_granted_reg};

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CNT_W'(NUM_BLOCKS))
        else $error("used count above map size");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("map written while idle");

    a_grant_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_GRANT) |-> (rem_reg != '0))
        else $error("granting with no blocks left to hand out");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken before the first finished");

endmodule

@@ bench/bitmap_block_allocator_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator_checker
// Watches the request, result and total_blocks channels of the allocator,
// keeps its own occupancy map and used count, works out the result beats each
// accepted request must produce and compares every result beat field by field.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [12:0] cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // block[11:0], count[18:12], zero[23:19]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // granted_block[11:0], granted_valid[12],
                                   // block_is_free[13], free_blocks[26:14],
                                   // used_blocks[39:27]
    input  logic [1:0]  m_tuser,   // status[1:0]
    input  logic        m_tlast,
    output int          error_count,
    output int          owed_count
);
    import bba_pkg::*;

    localparam int NBLK = NUM_BLOCKS_DEF;
    localparam int MRUN = MAX_RUN_DEF;

    typedef struct {
        status_t              status;
        logic [BLOCK_W-1:0]   granted_block;
        logic                 granted_valid;
        logic                 last;
        logic                 block_is_free;
        logic [TOTAL_W-1:0]   free_blocks;
        logic [TOTAL_W-1:0]   used_blocks;
    } alloc_result_t;

    logic               occupied [NBLK];
    int                 used_cnt;
    logic [TOTAL_W-1:0] total_reg;
    alloc_result_t      owed_results [$];
    int                 errors;

    initial begin
        errors = 0;
    end

    function automatic int managed_blocks();
        return (total_reg < NBLK) ? int'(total_reg) : NBLK;
    endfunction

    // queue one result beat, counts taken from the state after the update
    function automatic void owe(status_t st, int granted, logic gv, logic lst, logic bf);
        alloc_result_t r;
        int lim;
        lim = managed_blocks();
        r.status        = st;
        r.granted_block = granted[BLOCK_W-1:0];
        r.granted_valid = gv;
        r.last          = lst;
        r.block_is_free = bf;
        r.free_blocks   = (lim > used_cnt) ? TOTAL_W'(lim - used_cnt) : '0;
        r.used_blocks   = TOTAL_W'(used_cnt);
        owed_results.push_back(r);
    endfunction

    task automatic apply_request(kind_t k, logic [BLOCK_W-1:0] blk, logic [COUNT_W-1:0] cnt);
        int lim;
        int hits [$];
        lim = managed_blocks();
        if (k == K_ALLOC) begin
            if (cnt == 0) begin
                owe(S_OK, 0, 1'b0, 1'b1, 1'b0);
            end else if (cnt > MRUN) begin
                owe(S_NOSPACE, 0, 1'b0, 1'b1, 1'b0);
            end else begin
                // first fit: lowest free blocks below the managed total
                for (int i = 0; i < lim && hits.size() < cnt; i++) begin
                    if (!occupied[i]) hits.push_back(i);
                end
                if (hits.size() < cnt) begin
                    owe(S_NOSPACE, 0, 1'b0, 1'b1, 1'b0);
                end else begin
                    foreach (hits[j]) begin
                        occupied[hits[j]] = 1'b1;
                        used_cnt++;
                    end
                    foreach (hits[j]) owe(S_OK, hits[j], 1'b1, j == hits.size() - 1, 1'b0);
                end
            end
        end else if (int'(blk) >= lim) begin
            owe(S_RANGE, 0, 1'b0, 1'b1, 1'b0);
        end else begin
            case (k)
                K_FREE: begin
                    if (occupied[blk]) begin
                        occupied[blk] = 1'b0;
                        used_cnt--;
                    end
                    owe(S_OK, 0, 1'b0, 1'b1, 1'b0);
                end
                K_RESERVE: begin
                    if (!occupied[blk]) begin
                        occupied[blk] = 1'b1;
                        used_cnt++;
                    end
                    owe(S_OK, 0, 1'b0, 1'b1, 1'b0);
                end
                default: begin
                    owe(S_OK, 0, 1'b0, 1'b1, !occupied[blk]);
                end
            endcase
        end
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        alloc_result_t r;
        if (!aresetn) begin
            foreach (occupied[i]) occupied[i] = 1'b0;
            used_cnt  = 0;
            total_reg = TOTAL_W'(TOTAL_RESET);
            owed_results.delete();
        end else begin
            if (cfg_wr_en) total_reg = cfg_wr_data;
            if (m_tvalid && m_tready) begin
                if (owed_results.size() == 0) begin
                    $error("result beat with nothing owed: tuser %0d tdata %h tlast %0d",
                           m_tuser, m_tdata, m_tlast);
                    errors++;
                end else begin
                    r = owed_results.pop_front();
                    check_field("status", r.status, m_tuser);
                    check_field("granted_block", r.granted_block, m_tdata[11:0]);
                    check_field("granted_valid", r.granted_valid, m_tdata[12]);
                    check_field("last", r.last, m_tlast);
                    check_field("block_is_free", r.block_is_free, m_tdata[13]);
                    check_field("free_blocks", r.free_blocks, m_tdata[26:14]);
                    check_field("used_blocks", r.used_blocks, m_tdata[39:27]);
                end
            end
            if (s_tvalid && s_tready)
                apply_request(kind_t'(s_tuser), s_tdata[11:0], s_tdata[18:12]);
        end
        owed_count  <= owed_results.size();
        error_count <= errors;
    end

    final begin
        if (owed_results.size() != 0)
            $error("%0d result beats never arrived", owed_results.size());
    end

endmodule

@@ bench/bitmap_block_allocator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator_tb
// Drives requests and total_blocks writes into the allocator with random gaps
// on both channels and long result stalls; the checker beside the block does
// the prediction and comparison, this top makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_tb;
    import bba_pkg::*;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [12:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata     = '0;   // block[11:0], count[18:12], zero[23:19]
    logic [1:0]  s_tuser     = '0;   // kind[1:0]
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [39:0] m_tdata;            // granted_block[11:0], granted_valid[12],
                                     // block_is_free[13], free_blocks[26:14],
                                     // used_blocks[39:27]
    logic [1:0]  m_tuser;            // status[1:0]
    logic        m_tlast;

    int          error_count;
    int          owed_count;
    bit          no_idle = 1'b0;
    int          cur_total = TOTAL_RESET;
    int          result_beats = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    bitmap_block_allocator dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    bitmap_block_allocator_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .error_count (error_count),
        .owed_count  (owed_count)
    );

    task automatic send_request(kind_t k, int blk, int cnt);
        int gap;
        logic [11:0] b;
        logic [6:0]  c;
        b   = blk[11:0];
        c   = cnt[6:0];
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, c, b};
        s_tuser  <= k;
        do @(posedge aclk); while (!s_tready);
    endtask

    // only once the block has drained and settled
    task automatic set_total(int v);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (owed_count != 0);
        repeat (24) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v[12:0];
        cur_total   = v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // mostly blocks where allocations live or near the total edge
    function automatic int pick_block();
        int eff;
        int r;
        eff = (cur_total < NUM_BLOCKS_DEF) ? cur_total : NUM_BLOCKS_DEF;
        r   = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, (eff < 120) ? eff + 4 : 127);
        if (r < 85) return (eff + $urandom_range(0, 3) - 2 + 4096) % 4096;
        return $urandom_range(0, 4095);
    endfunction

    task automatic random_request();
        int r;
        int sel;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            sel = $urandom_range(0, 19);
            if (sel == 0)
                send_request(K_ALLOC, $urandom_range(0, 4095), 0);
            else if (sel == 1)
                send_request(K_ALLOC, $urandom_range(0, 4095), $urandom_range(65, 127));
            else if (sel < 4)
                send_request(K_ALLOC, $urandom_range(0, 4095), $urandom_range(9, 64));
            else
                send_request(K_ALLOC, $urandom_range(0, 4095), $urandom_range(1, 8));
        end else if (r < 60) begin
            send_request(K_FREE, pick_block(), $urandom_range(0, 127));
        end else if (r < 75) begin
            send_request(K_RESERVE, pick_block(), $urandom_range(0, 127));
        end else begin
            send_request(K_QUERY, pick_block(), $urandom_range(0, 127));
        end
    endtask

    // result side: random gaps per beat and two long stalls
    initial begin
        int gap;
        wait (aresetn);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            result_beats++;
            if (result_beats == 50 || result_beats == 300) begin
                m_tready <= 1'b0;
                repeat (600) @(posedge aclk);
            end
        end
    end

    initial begin
        int totals [4];
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        // clearing pass runs first
        do @(posedge aclk); while (!s_tready);

        set_total(8191);
        send_request(K_QUERY, 0, 0);
        send_request(K_ALLOC, 0, 0);
        send_request(K_ALLOC, 0, 65);
        send_request(K_ALLOC, 0, 127);
        send_request(K_ALLOC, 4095, 64);
        send_request(K_ALLOC, 0, 1);
        send_request(K_RESERVE, 4095, 0);
        send_request(K_RESERVE, 4095, 0);
        send_request(K_QUERY, 4095, 127);
        send_request(K_FREE, 4095, 0);
        send_request(K_FREE, 4095, 0);
        send_request(K_FREE, 10, 0);
        send_request(K_ALLOC, 0, 3);
        send_request(K_RESERVE, 12'hAAA, 0);
        send_request(K_QUERY, 12'h555, 42);
        send_request(K_RESERVE, 12'h555, 85);
        send_request(K_FREE, 0, 0);
        send_request(K_QUERY, 0, 0);

        // total below the used count: free count saturates, upper blocks out of range
        set_total(40);
        send_request(K_QUERY, 39, 0);
        send_request(K_FREE, 40, 0);
        send_request(K_RESERVE, 4095, 0);
        send_request(K_ALLOC, 0, 2);
        send_request(K_ALLOC, 0, 1);

        set_total(0);
        send_request(K_ALLOC, 0, 1);
        send_request(K_QUERY, 0, 0);

        totals = '{24, 4096, $urandom_range(64, 4095), 8191};
        foreach (totals[p]) begin
            set_total(totals[p]);
            no_idle = (p == 1);
            repeat (26) random_request();
        end
        no_idle = 1'b0;

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (owed_count != 0);
        repeat (40) @(posedge aclk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/bba_pkg.sv
rtl/core/bba_word_eval.sv
rtl/core/bitmap_block_allocator.sv
bench/bitmap_block_allocator_checker.sv
bench/bitmap_block_allocator_tb.sv
